// File: src/evt_pkg.sv
// ----------------------------------------------------------------------------
// evt_pkg
// Shared widths, constants, beat types and fixed-point helpers for the
// vertex transform pipeline.
// ----------------------------------------------------------------------------
package evt_pkg;

    // coordinate and angle widths
    localparam int CW   = 32;
    localparam int AW   = 16;
    // Q2.30 trig width and fraction bits
    localparam int QW   = 32;
    localparam int QF   = 30;
    // coordinate fraction bits
    localparam int FRAC = 16;
    // matrix entry width, one extra bit for sums of two terms
    localparam int MTW  = QW + 1;
    // working width of the rounding and clipping helpers
    localparam int MW   = 2 * CW + 16;
    // register stages from input beat to result register
    localparam int NS   = 10;

    // polynomial coefficients of sin(pi/2 * t), Q2.30
    localparam logic signed [QW-1:0] Q_ONE  = QW'(64'd1 << QF);
    localparam logic signed [QW-1:0] SIN_A1 = QW'(1686629713);
    localparam logic signed [QW-1:0] SIN_A3 = QW'(693598669);
    localparam logic signed [QW-1:0] SIN_A5 = QW'(85569306);
    localparam logic signed [QW-1:0] SIN_A7 = QW'(5026996);
    localparam logic signed [QW-1:0] SIN_A9 = QW'(172272);

    typedef struct packed {
        logic signed [CW-1:0] vertex_x;
        logic signed [CW-1:0] vertex_y;
        logic signed [CW-1:0] vertex_z;
        logic signed [CW-1:0] scale_x;
        logic signed [CW-1:0] scale_y;
        logic signed [CW-1:0] scale_z;
        logic signed [AW-1:0] angle_x;
        logic signed [AW-1:0] angle_y;
        logic signed [AW-1:0] angle_z;
        logic signed [CW-1:0] offset_x;
        logic signed [CW-1:0] offset_y;
        logic signed [CW-1:0] offset_z;
    } vertex_item_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 saturated;
    } result_t;

    typedef struct packed {
        logic                 sat;
        logic signed [CW-1:0] val;
    } clip_t;

    // arithmetic shift right by k, round to nearest, ties away from zero
    function automatic logic signed [MW-1:0] rnd_shr(input logic signed [MW-1:0] p,
                                                     input int k);
        logic signed [MW-1:0] half;
        logic signed [MW-1:0] bias;
        half = MW'(1) <<< (k - 1);
        bias = p[MW-1] ? half - MW'(1) : half;
        return (p + bias) >>> k;
    endfunction

    // clip to the coordinate range and flag it
    function automatic clip_t clip_coord(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] hi;
        logic signed [MW-1:0] lo;
        clip_t                c;
        hi = (MW'(1) <<< (CW - 1)) - MW'(1);
        lo = -hi - MW'(1);
        c.sat = 1'b0;
        c.val = CW'(v);
        if (v > hi) begin
            c.sat = 1'b1;
            c.val = CW'(hi);
        end
        else if (v < lo) begin
            c.sat = 1'b1;
            c.val = CW'(lo);
        end
        return c;
    endfunction

endpackage

// File: src/evt_sine_pipe.sv
// ----------------------------------------------------------------------------
// evt_sine_pipe
// Six-stage sine of a binary angle: quadrant fold, t squared, four Horner
// steps and the final multiply by t with clamp and sign, one multiply a stage.
// ----------------------------------------------------------------------------
module evt_sine_pipe (
    input  logic                           clk,
    input  logic [5:0]                     en,
    input  logic [evt_pkg::AW-1:0]         phase,
    output logic signed [evt_pkg::QW-1:0]  sine
);

    localparam int QW = evt_pkg::QW;
    localparam int AW = evt_pkg::AW;
    localparam int QF = evt_pkg::QF;
    localparam int MW = evt_pkg::MW;

    // constant added after each Horner multiply, by stage
    localparam logic signed [QW-1:0] HORNER_ADD [2:5] = '{
        -evt_pkg::SIN_A7, evt_pkg::SIN_A5, -evt_pkg::SIN_A3, evt_pkg::SIN_A1
    };

    logic [1:0]             quad;
    logic [QW-1:0]          t_frac;
    logic signed [QW-1:0]   t_first;
    logic signed [2*QW-1:0] sq_prod;
    logic signed [QW-1:0]   t_reg   [1:5];
    logic                   neg_reg [1:5];
    logic signed [QW-1:0]   t2_reg  [1:4];
    logic signed [QW-1:0]   r_reg   [2:5];
    logic signed [2*QW-1:0] h_prod  [2:5];
    logic signed [QW-1:0]   r_next  [2:5];
    logic signed [2*QW-1:0] fin_prod;
    logic signed [QW-1:0]   fin_rnd;
    logic signed [QW-1:0]   mag;
    logic signed [QW-1:0]   sine_next;
    logic signed [QW-1:0]   sine_reg;

    // quadrant fold and t squared
    always_comb
    begin
        quad    = phase[AW-1:AW-2];
        t_frac  = QW'(phase[AW-3:0]) << (QF - (AW - 2));
        t_first = quad[0] ? evt_pkg::Q_ONE - $signed(t_frac) : $signed(t_frac);
        sq_prod = t_first * t_first;
    end

    // horner steps
    always_comb
    begin
        for (int k = 2; k <= 5; k++) begin
            if (k == 2)
                h_prod[k] = evt_pkg::SIN_A9 * t2_reg[k-1];
            else
                h_prod[k] = r_reg[k-1] * t2_reg[k-1];
            r_next[k] = HORNER_ADD[k] + QW'(evt_pkg::rnd_shr(MW'(h_prod[k]), QF));
        end
    end

    // final multiply by t, clamp to [0, 1], apply quadrant sign
    always_comb
    begin
        fin_prod = r_reg[5] * t_reg[5];
        fin_rnd  = QW'(evt_pkg::rnd_shr(MW'(fin_prod), QF));
        mag      = fin_rnd;
        if (fin_rnd < 0)
            mag = '0;
        else if (fin_rnd > evt_pkg::Q_ONE)
            mag = evt_pkg::Q_ONE;
        sine_next = neg_reg[5] ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            t_reg[1]   <= t_first;
            neg_reg[1] <= quad[1];
            t2_reg[1]  <= QW'(evt_pkg::rnd_shr(MW'(sq_prod), QF));
        end
        for (int k = 2; k <= 5; k++) begin
            if (en[k-1]) begin
                t_reg[k]   <= t_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                r_reg[k]   <= r_next[k];
                if (k <= 4)
                    t2_reg[k] <= t2_reg[k-1];
            end
        end
        if (en[5])
            sine_reg <= sine_next;
    end

    assign sine = sine_reg;

endmodule

// File: src/evt_matrix.sv
// ----------------------------------------------------------------------------
// evt_matrix
// Builds the 3x3 Euler rotation matrix in two stages: pairwise trig
// products, then the triple products with their sums.
// ----------------------------------------------------------------------------
module evt_matrix (
    input  logic                           clk,
    input  logic [1:0]                     en,
    input  logic signed [evt_pkg::QW-1:0]  sx,
    input  logic signed [evt_pkg::QW-1:0]  cx,
    input  logic signed [evt_pkg::QW-1:0]  sy,
    input  logic signed [evt_pkg::QW-1:0]  cy,
    input  logic signed [evt_pkg::QW-1:0]  sz,
    input  logic signed [evt_pkg::QW-1:0]  cz,
    output logic signed [evt_pkg::MTW-1:0] mat [3][3]
);

    localparam int QW  = evt_pkg::QW;
    localparam int MTW = evt_pkg::MTW;

    function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return QW'(evt_pkg::rnd_shr(evt_pkg::MW'(p), evt_pkg::QF));
    endfunction

    logic signed [QW-1:0]  cysz_reg, sysz_reg, cycz_reg, sycz_reg, czsx_reg, czcx_reg;
    logic signed [QW-1:0]  sycx_reg, sysx_reg, cycx_reg, cysx_reg;
    logic signed [QW-1:0]  sx_reg, cx_reg, sz_reg;
    logic signed [MTW-1:0] mat_reg [3][3];

    always_ff @(posedge clk)
    begin
        // pairwise products
        if (en[0]) begin
            cysz_reg <= qmul(cy, sz);
            sysz_reg <= qmul(sy, sz);
            cycz_reg <= qmul(cy, cz);
            sycz_reg <= qmul(sy, cz);
            czsx_reg <= qmul(cz, sx);
            czcx_reg <= qmul(cz, cx);
            sycx_reg <= qmul(sy, cx);
            sysx_reg <= qmul(sy, sx);
            cycx_reg <= qmul(cy, cx);
            cysx_reg <= qmul(cy, sx);
            sx_reg   <= sx;
            cx_reg   <= cx;
            sz_reg   <= sz;
        end
        // matrix entries
        if (en[1]) begin
            mat_reg[0][0] <= MTW'(cycz_reg);
            mat_reg[0][1] <= MTW'(qmul(cysz_reg, sx_reg)) - MTW'(sycx_reg);
            mat_reg[0][2] <= MTW'(qmul(cysz_reg, cx_reg)) + MTW'(sysx_reg);
            mat_reg[1][0] <= MTW'(sycz_reg);
            mat_reg[1][1] <= MTW'(qmul(sysz_reg, sx_reg)) + MTW'(cycx_reg);
            mat_reg[1][2] <= MTW'(qmul(sysz_reg, cx_reg)) - MTW'(cysx_reg);
            mat_reg[2][0] <= -MTW'(sz_reg);
            mat_reg[2][1] <= MTW'(czsx_reg);
            mat_reg[2][2] <= MTW'(czcx_reg);
        end
    end

    assign mat = mat_reg;

endmodule

// File: src/evt_apply.sv
// ----------------------------------------------------------------------------
// evt_apply
// Rotates the scaled vertex by the matrix and translates it: nine rounded
// products in one stage, sums, offsets and clipping in the next.
// ----------------------------------------------------------------------------
module evt_apply (
    input  logic                           clk,
    input  logic [1:0]                     en,
    input  logic signed [evt_pkg::CW-1:0]  vec  [3],
    input  logic signed [evt_pkg::MTW-1:0] mat  [3][3],
    input  logic signed [evt_pkg::CW-1:0]  offs [3],
    input  logic                           sat_in,
    output evt_pkg::result_t               result
);

    localparam int CW  = evt_pkg::CW;
    localparam int MTW = evt_pkg::MTW;
    localparam int MW  = evt_pkg::MW;
    localparam int PW  = CW + MTW - evt_pkg::QF + 2;
    localparam int SW  = PW + 2;

    logic signed [CW+MTW-1:0] prod [3][3];
    logic signed [PW-1:0]     prod_reg [3][3];
    logic signed [CW-1:0]     off_reg  [3];
    logic                     sat_reg;
    logic signed [SW-1:0]     sum  [3];
    evt_pkg::clip_t           rot  [3];
    evt_pkg::clip_t           tra  [3];
    evt_pkg::result_t         result_next;
    evt_pkg::result_t         result_reg;

    // rounded products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod[i][j] = vec[j] * mat[i][j];
    end

    // row sums, rotate clip, translate clip
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);
            rot[i] = evt_pkg::clip_coord(MW'(sum[i]));
            tra[i] = evt_pkg::clip_coord(MW'(rot[i].val) + MW'(off_reg[i]));
        end
        result_next.out_x     = tra[0].val;
        result_next.out_y     = tra[1].val;
        result_next.out_z     = tra[2].val;
        result_next.saturated = sat_reg | rot[0].sat | rot[1].sat | rot[2].sat
                              | tra[0].sat | tra[1].sat | tra[2].sat;
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= PW'(evt_pkg::rnd_shr(MW'(prod[i][j]), evt_pkg::QF));
                off_reg[i] <= offs[i];
            end
            sat_reg <= sat_in;
        end
        if (en[1])
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// File: src/euler_vertex_transform.sv
// ----------------------------------------------------------------------------
// euler_vertex_transform
// Scale, Euler rotate and translate one Q16.16 vertex per beat.
// ----------------------------------------------------------------------------
// One vertex beat is taken every clock while vertex_stall is low. Its result
// passes ten register stages on its way to the result register. The sine chain
// (quadrant fold and t squared, four Horner steps, final multiply) takes six
// stages, then come two matrix stages and two apply stages, each stage but the
// last apply stage holding one multiply.
// Each stage advances when it is empty or the next one advances, so stalls
// on the output back up without losing or repeating beats. The saturated
// flag reports clipping in the scale, rotate or translate step.
module euler_vertex_transform (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vertex_valid,
    output logic                  vertex_stall,
    input  evt_pkg::vertex_item_t vertex,
    output logic                  result_valid,
    input  logic                  result_stall,
    output evt_pkg::result_t      result
);

    localparam int CW = evt_pkg::CW;
    localparam int AW = evt_pkg::AW;
    localparam int QW = evt_pkg::QW;
    localparam int MW = evt_pkg::MW;
    localparam int NS = evt_pkg::NS;
    localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);

    logic [NS:1]                v_reg;
    logic [NS:1]                en;
    logic signed [CW-1:0]       vin   [3];
    logic signed [CW-1:0]       sin_v [3];
    logic signed [2*CW-1:0]     sprod [3];
    evt_pkg::clip_t             sclip [3];
    logic signed [CW-1:0]       vsc_reg [1:8][3];
    logic signed [CW-1:0]       off_reg [1:8][3];
    logic                       sat_reg [1:8];
    logic [AW-1:0]              phase [6];
    logic signed [QW-1:0]       trig  [6];
    logic signed [evt_pkg::MTW-1:0] mat [3][3];

    // stage enables, each stage loads when empty or draining
    always_comb
    begin
        en[NS] = !v_reg[NS] || !result_stall;
        for (int k = NS - 1; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign vertex_stall = !en[1];
    assign result_valid = v_reg[NS];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[1])
                v_reg[1] <= vertex_valid;
            for (int k = 2; k <= NS; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // axis scaling
    always_comb
    begin
        vin[0]   = vertex.vertex_x;
        vin[1]   = vertex.vertex_y;
        vin[2]   = vertex.vertex_z;
        sin_v[0] = vertex.scale_x;
        sin_v[1] = vertex.scale_y;
        sin_v[2] = vertex.scale_z;
        for (int i = 0; i < 3; i++) begin
            sprod[i] = vin[i] * sin_v[i];
            sclip[i] = evt_pkg::clip_coord(evt_pkg::rnd_shr(MW'(sprod[i]), evt_pkg::FRAC));
        end
    end

    // scaled vertex, offsets and flag carried to the apply stages
    always_ff @(posedge clk)
    begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++)
                vsc_reg[1][i] <= sclip[i].val;
            off_reg[1][0] <= vertex.offset_x;
            off_reg[1][1] <= vertex.offset_y;
            off_reg[1][2] <= vertex.offset_z;
            sat_reg[1]    <= sclip[0].sat | sclip[1].sat | sclip[2].sat;
        end
        for (int k = 2; k <= 8; k++) begin
            if (en[k]) begin
                vsc_reg[k] <= vsc_reg[k-1];
                off_reg[k] <= off_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    // sine and cosine phases: x, y, z
    always_comb
    begin
        phase[0] = vertex.angle_x;
        phase[1] = vertex.angle_x + QUARTER;
        phase[2] = vertex.angle_y;
        phase[3] = vertex.angle_y + QUARTER;
        phase[4] = vertex.angle_z;
        phase[5] = vertex.angle_z + QUARTER;
    end

    for (genvar g = 0; g < 6; g++) begin : g_trig
        evt_sine_pipe u_sine (
            .clk   (clk),
            .en    (en[6:1]),
            .phase (phase[g]),
            .sine  (trig[g])
        );
    end

    evt_matrix u_matrix (
        .clk (clk),
        .en  (en[8:7]),
        .sx  (trig[0]),
        .cx  (trig[1]),
        .sy  (trig[2]),
        .cy  (trig[3]),
        .sz  (trig[4]),
        .cz  (trig[5]),
        .mat (mat)
    );

    evt_apply u_apply (
        .clk    (clk),
        .en     (en[10:9]),
        .vec    (vsc_reg[8]),
        .mat    (mat),
        .offs   (off_reg[8]),
        .sat_in (sat_reg[8]),
        .result (result)
    );

`ifndef SYNTH
    // beats in flight change only by accepted and delivered beats
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(v_reg) == $countones($past(v_reg))
            + ($past(vertex_valid && !vertex_stall) ? 1 : 0)
            - ($past(result_valid && !result_stall) ? 1 : 0))
        else $error("pipeline beat count mismatch");

    // an empty first stage always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[1] |-> !vertex_stall)
        else $error("input stalled with empty first stage");

    // a result drops only after it was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(!result_stall))
        else $error("result dropped without a beat");
`endif

endmodule

// File: sim/euler_vertex_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_vertex_transform_tb
// Sends vertex beats with random bursts and gaps, stalls the result side on
// its own pattern, and checks every result beat against a bit-exact predictor
// of the scale, rotate and translate arithmetic.
// ----------------------------------------------------------------------------
module euler_vertex_transform_tb;

    localparam int     CW        = evt_pkg::CW;
    localparam int     AW        = evt_pkg::AW;
    localparam int     NS        = evt_pkg::NS;
    localparam longint CAP       = 64'sd1 << 62;
    localparam longint ONE30     = 64'sd1 << 30;
    localparam int     IDLE_MAX  = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  vertex_valid;
    logic                  vertex_stall;
    evt_pkg::vertex_item_t vertex;
    logic                  result_valid;
    logic                  result_stall;
    evt_pkg::result_t      result;

    evt_pkg::vertex_item_t pending_q[$];
    evt_pkg::result_t      expected_q[$];
    int           errors;
    int           idle_cycles;
    int           burst_left;
    int           gap_left;
    int           hold_left;
    bit           hold_request;
    bit           stim_done;

    euler_vertex_transform dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // (a*b) >> k, round half away from zero, magnitude capped at 2^62
    function automatic longint mul_round(input longint a, input longint b, input int k);
        logic signed [127:0] p;
        logic        [127:0] mag;
        p = 128'(a) * 128'(b);
        mag = p[127] ? -p : p;
        mag = (mag + (128'd1 << (k - 1))) >> k;
        if (mag > 128'(CAP))
            mag = 128'(CAP);
        return p[127] ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint clamp_coord(input longint v, inout bit clipped);
        longint hi;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        if (v > hi)
        begin
            clipped = 1'b1;
            return hi;
        end
        if (v < -hi - 1)
        begin
            clipped = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    // sine of a binary angle, Q2.30
    function automatic longint angle_sine(input logic [AW-1:0] phase);
        logic [1:0]    quad;
        longint        t;
        longint        t2;
        longint        r;
        quad = phase[AW-1:AW-2];
        t = longint'(phase[AW-3:0]) << (30 - (AW - 2));
        if (quad[0])
            t = ONE30 - t;
        t2 = mul_round(t, t, 30);
        r = 172272;
        r = -5026996 + mul_round(r, t2, 30);
        r = 85569306 + mul_round(r, t2, 30);
        r = -693598669 + mul_round(r, t2, 30);
        r = 1686629713 + mul_round(r, t2, 30);
        r = mul_round(r, t, 30);
        if (r < 0)
            r = 0;
        if (r > ONE30)
            r = ONE30;
        return quad[1] ? -r : r;
    endfunction

    function automatic evt_pkg::result_t transform_vertex(input evt_pkg::vertex_item_t it);
        longint  sx, cx, sy, cy, sz, cz, cysz, sysz, acc;
        longint  v[3];
        longint  m[3][3];
        longint  off[3];
        evt_pkg::result_t r;
        bit      clipped;
        clipped = 1'b0;
        sx = angle_sine(it.angle_x);
        cx = angle_sine(it.angle_x + AW'(1 << (AW - 2)));
        sy = angle_sine(it.angle_y);
        cy = angle_sine(it.angle_y + AW'(1 << (AW - 2)));
        sz = angle_sine(it.angle_z);
        cz = angle_sine(it.angle_z + AW'(1 << (AW - 2)));
        cysz = mul_round(cy, sz, 30);
        sysz = mul_round(sy, sz, 30);
        // scale stage
        v[0] = clamp_coord(mul_round(longint'(it.vertex_x), longint'(it.scale_x), 16), clipped);
        v[1] = clamp_coord(mul_round(longint'(it.vertex_y), longint'(it.scale_y), 16), clipped);
        v[2] = clamp_coord(mul_round(longint'(it.vertex_z), longint'(it.scale_z), 16), clipped);
        // rotation matrix
        m[0][0] = mul_round(cy, cz, 30);
        m[0][1] = mul_round(cysz, sx, 30) - mul_round(sy, cx, 30);
        m[0][2] = mul_round(cysz, cx, 30) + mul_round(sy, sx, 30);
        m[1][0] = mul_round(sy, cz, 30);
        m[1][1] = mul_round(sysz, sx, 30) + mul_round(cy, cx, 30);
        m[1][2] = mul_round(sysz, cx, 30) - mul_round(cy, sx, 30);
        m[2][0] = -sz;
        m[2][1] = mul_round(cz, sx, 30);
        m[2][2] = mul_round(cz, cx, 30);
        off[0] = longint'(it.offset_x);
        off[1] = longint'(it.offset_y);
        off[2] = longint'(it.offset_z);
        // rotate and translate
        for (int i = 0; i < 3; i++)
        begin
            acc = mul_round(v[0], m[i][0], 30) + mul_round(v[1], m[i][1], 30)
                + mul_round(v[2], m[i][2], 30);
            acc = clamp_coord(acc, clipped);
            acc = clamp_coord(acc + off[i], clipped);
            if (i == 0)
                r.out_x = CW'(acc);
            else if (i == 1)
                r.out_y = CW'(acc);
            else
                r.out_z = CW'(acc);
        end
        r.saturated = clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // coordinate picker: mostly moderate, sometimes extreme or fully random
    function automatic logic [CW-1:0] pick_coord(input int span);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return CW'($urandom);
        if (sel == 1)
            return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        return CW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic evt_pkg::vertex_item_t random_vertex();
        evt_pkg::vertex_item_t it;
        it.vertex_x = pick_coord(200 << 16);
        it.vertex_y = pick_coord(200 << 16);
        it.vertex_z = pick_coord(200 << 16);
        it.scale_x  = pick_coord(4 << 16);
        it.scale_y  = pick_coord(4 << 16);
        it.scale_z  = pick_coord(4 << 16);
        it.angle_x  = AW'($urandom);
        it.angle_y  = AW'($urandom);
        it.angle_z  = AW'($urandom);
        it.offset_x = pick_coord(1000 << 16);
        it.offset_y = pick_coord(1000 << 16);
        it.offset_z = pick_coord(1000 << 16);
        return it;
    endfunction

    function automatic evt_pkg::vertex_item_t directed_vertex(input logic [CW-1:0] c,
                                                              input logic [CW-1:0] s,
                                                              input logic [AW-1:0] a,
                                                              input logic [CW-1:0] o);
        evt_pkg::vertex_item_t it;
        it = '{c, c, c, s, s, s, a, a, a, o, o, o};
        return it;
    endfunction

    // stimulus
    initial
    begin
        logic [CW-1:0] cmax;
        logic [CW-1:0] cmin;
        logic [AW-1:0] amax;
        logic [AW-1:0] amin;
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        amax = {1'b0, {(AW-1){1'b1}}};
        amin = {1'b1, {(AW-1){1'b0}}};
        stim_done = 1'b0;
        hold_request = 1'b0;
        // zero, identity, quarter turns, extremes, scale and translate clipping
        pending_q.push_back(directed_vertex('0, '0, '0, '0));
        pending_q.push_back(directed_vertex(CW'(1 << 16), CW'(1 << 16), '0, '0));
        pending_q.push_back(directed_vertex(CW'(3 << 16), CW'(1 << 16), AW'(1 << (AW-2)), '0));
        pending_q.push_back(directed_vertex(CW'(3 << 16), CW'(1 << 16), AW'(1 << (AW-1)), '0));
        pending_q.push_back(directed_vertex(CW'(3 << 16), CW'(1 << 16), AW'(3 << (AW-2)), '0));
        pending_q.push_back(directed_vertex(CW'(5 << 16), CW'(2 << 16), amax, CW'(7)));
        pending_q.push_back(directed_vertex(CW'(5 << 16), CW'(2 << 16), amin, CW'(-7)));
        pending_q.push_back(directed_vertex(cmax, CW'(1 << 16), '0, '0));
        pending_q.push_back(directed_vertex(cmin, CW'(1 << 16), '0, '0));
        pending_q.push_back(directed_vertex(cmax, cmax, AW'(8192), '0));
        pending_q.push_back(directed_vertex(cmin, cmin, AW'(8192), '0));
        pending_q.push_back(directed_vertex(cmax, cmin, AW'(5000), cmax));
        pending_q.push_back(directed_vertex(cmax, CW'(1 << 16), '0, cmax));
        pending_q.push_back(directed_vertex(cmin, CW'(1 << 16), '0, cmin));
        pending_q.push_back(directed_vertex(cmax, CW'(1 << 16), AW'(8192), '0));
        pending_q.push_back(directed_vertex(CW'(-(2 << 16)), CW'(-(3 << 16)), AW'(12345), cmin));
        pending_q.push_back(directed_vertex('1, '1, '1, '1));
        pending_q.push_back(directed_vertex(CW'(1), CW'(1), AW'(1), CW'(1)));
        pending_q.push_back(directed_vertex(CW'(32768), CW'(1), AW'(-1), '0));
        pending_q.push_back(directed_vertex(CW'(-32768), CW'(1), AW'(2), '0));
        for (int i = 0; i < 1400; i++)
        begin
            pending_q.push_back(random_vertex());
            // long output hold-off partway through
            if (i == 400)
            begin
                wait (pending_q.size() < 50);
                hold_request = 1'b1;
            end
        end
        wait (pending_q.size() == 0 && !(vertex_valid && vertex_stall));
        @(posedge clk);
        while (vertex_valid)
            @(posedge clk);
        stim_done = 1'b1;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_valid <= 1'b0;
            vertex       <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else if (!(vertex_valid && vertex_stall))
        begin
            if (vertex_valid)
                expected_q.push_back(transform_vertex(vertex));
            if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                vertex_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                vertex_valid <= 1'b1;
                vertex       <= pending_q.pop_front();
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                vertex_valid <= 1'b0;
        end
    end

    // receiver: own stall pattern plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_request && hold_left == 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= -1;
        end
        else if (hold_left < 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= (hold_left <= -200) ? 1 : hold_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       result_stall <= 1'b1;
                1:       result_stall <= ($urandom_range(0, 7) == 0);
                default: result_stall <= 1'b0;
            endcase
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        evt_pkg::result_t want;
        if (rst_n)
        begin
            if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (result.out_x !== want.out_x)
                        report_mismatch("out_x", longint'(result.out_x), longint'(want.out_x));
                    if (result.out_y !== want.out_y)
                        report_mismatch("out_y", longint'(result.out_y), longint'(want.out_y));
                    if (result.out_z !== want.out_z)
                        report_mismatch("out_z", longint'(result.out_z), longint'(want.out_z));
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", result.saturated, want.saturated);
                end
            end
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("watchdog expired");
                $display("euler_vertex_transform_tb NOT OK");
                $finish;
            end
        end
    end

    // end of run
    initial
    begin
        errors = 0;
        idle_cycles = 0;
        wait (stim_done);
        wait (expected_q.size() == 0);
        repeat (4 * NS + 20) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results left over", expected_q.size(), 0);
        if (errors == 0)
            $display("euler_vertex_transform_tb OK");
        else
            $display("euler_vertex_transform_tb NOT OK");
        $finish;
    end

endmodule
